// ===== rtl/lbps_pkg.sv =====
// Package for the LED blink pattern sequencer.
// Holds the state record and the constant pattern tables; no dependencies.
package lbps_pkg;

   localparam int unsigned ELAPSED_W = 13;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

   localparam logic [2:0] PAT_EMPTY         = 3'd0;
   localparam logic [2:0] PAT_ERROR         = 3'd1;
   localparam logic [2:0] PAT_REQUEST       = 3'd2;
   localparam logic [2:0] PAT_PAUSE         = 3'd3;
   localparam logic [2:0] PAT_MOVE          = 3'd4;
   localparam logic [2:0] PAT_STANDBY       = 3'd5;
   localparam logic [2:0] PAT_STANDBY_NOLNK = 3'd6;
   localparam logic [2:0] PAT_ERROR_ALT     = 3'd7;

   localparam logic [ELAPSED_W-1:0] DUR_SHORT        = 13'd50;
   localparam logic [ELAPSED_W-1:0] DUR_ERROR_LAST   = 13'd750;
   localparam logic [ELAPSED_W-1:0] DUR_PAUSE_LAST   = 13'd850;
   localparam logic [ELAPSED_W-1:0] DUR_MOVE_LAST    = 13'd450;
   localparam logic [ELAPSED_W-1:0] DUR_STANDBY_LAST = 13'd4950;
   localparam logic [ELAPSED_W-1:0] DUR_NOLINK_LAST  = 13'd4750;

   typedef struct packed {
      logic [2:0]           pattern;
      logic [2:0]           step;
      logic [ELAPSED_W-1:0] elapsed;
      logic                 running;
      logic                 led;
      logic                 last_run;
   } lbps_state_type;

   function automatic logic [2:0] pattern_len(input logic [2:0] pat);
      logic [2:0] len;
      unique case (pat)
         PAT_EMPTY:         len = 3'd0;
         PAT_ERROR:         len = 3'd6;
         PAT_REQUEST:       len = 3'd4;
         PAT_PAUSE:         len = 3'd4;
         PAT_MOVE:          len = 3'd2;
         PAT_STANDBY:       len = 3'd2;
         PAT_STANDBY_NOLNK: len = 3'd6;
         PAT_ERROR_ALT:     len = 3'd6;
      endcase
      return len;
   endfunction

   // Duration of the last step of each pattern; all other steps are short.
   function automatic logic [ELAPSED_W-1:0] last_dur(input logic [2:0] pat);
      logic [ELAPSED_W-1:0] dur;
      unique case (pat)
         PAT_EMPTY:         dur = '0;
         PAT_ERROR:         dur = DUR_ERROR_LAST;
         PAT_REQUEST:       dur = DUR_SHORT;
         PAT_PAUSE:         dur = DUR_PAUSE_LAST;
         PAT_MOVE:          dur = DUR_MOVE_LAST;
         PAT_STANDBY:       dur = DUR_STANDBY_LAST;
         PAT_STANDBY_NOLNK: dur = DUR_NOLINK_LAST;
         PAT_ERROR_ALT:     dur = DUR_ERROR_LAST;
      endcase
      return dur;
   endfunction

   // Steps past the end of the pattern count as zero length.
   function automatic logic [ELAPSED_W-1:0] step_dur(input logic [2:0] pat,
                                                     input logic [2:0] step);
      logic [2:0]           len;
      logic [ELAPSED_W-1:0] dur;
      len = pattern_len(pat);
      if (step >= len) begin
         dur = '0;
      end else if (step == len - 3'd1) begin
         dur = last_dur(pat);
      end else begin
         dur = DUR_SHORT;
      end
      return dur;
   endfunction

   // Even steps are on, odd steps off, in every pattern.
   function automatic logic step_lvl(input logic [2:0] pat, input logic [2:0] step);
      return (step < pattern_len(pat)) && !step[0];
   endfunction

endpackage

// ===== rtl/led_blink_pattern_sequencer.sv =====
// Top level of the LED blink pattern sequencer: state and result registers.
// Depends on lbps_pkg and lbps_next.
//
//   channel  direction  ports
//   req      in         req_valid, req_ready, req_sequence_req, req_run, req_tick
//   rsp      out        rsp_valid, rsp_ready, rsp_led_on, rsp_step_index,
//                       rsp_running, rsp_step_advanced
//
// One item per cycle unless stalled; the result is registered on acceptance.
// The result register frees up in the cycle it is taken, so req_ready stays high
// while rsp_ready is high. A stalled result holds and blocks only new items.
// Synchronous reset clears the sequencer state and drops any pending result.
module led_blink_pattern_sequencer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_sequence_req,
   input  logic       req_run,
   input  logic       req_tick,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_led_on,
   output logic [2:0] rsp_step_index,
   output logic       rsp_running,
   output logic       rsp_step_advanced
);
   import lbps_pkg::*;

   lbps_state_type state_ff, state_in;
   logic           adv_in;
   logic           rsp_valid_ff;
   logic           led_ff;
   logic [2:0]     step_ff;
   logic           running_ff;
   logic           adv_ff;
   logic           accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   lbps_next u_next (
      .cur          (state_ff),
      .sequence_req (req_sequence_req),
      .run          (req_run),
      .tick         (req_tick),
      .nxt          (state_in),
      .advanced     (adv_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         led_ff <= state_in.led;
         step_ff <= state_in.step;
         running_ff <= state_in.running;
         adv_ff <= adv_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_led_on        = led_ff;
   assign rsp_step_index    = step_ff;
   assign rsp_running       = running_ff;
   assign rsp_step_advanced = adv_ff;

endmodule

// ===== rtl/lbps_next.sv =====
// Next-state logic for one item of the LED blink pattern sequencer.
// Depends on lbps_pkg for the state record and pattern tables.
module lbps_next (
   input  lbps_pkg::lbps_state_type cur,
   input  logic [2:0]               sequence_req,
   input  logic                     run,
   input  logic                     tick,
   output lbps_pkg::lbps_state_type nxt,
   output logic                     advanced
);
   import lbps_pkg::*;

   logic [2:0]           len;
   logic [ELAPSED_W-1:0] dur;
   logic [3:0]           step_inc;
   logic [2:0]           step_wrap;

   always_comb begin
      nxt = cur;
      advanced = 1'b0;
      len = '0;
      dur = '0;
      step_inc = '0;
      step_wrap = '0;

      if (sequence_req != cur.pattern) begin
         nxt.pattern = sequence_req;
         nxt.step = '0;
      end

      if (run && !cur.last_run) begin
         nxt.step = '0;
         nxt.running = 1'b1;
      end else if (!run && cur.last_run) begin
         nxt.led = 1'b0;
         nxt.running = 1'b0;
      end
      nxt.last_run = run;

      if (nxt.running) begin
         len = pattern_len(nxt.pattern);
         if (tick && nxt.elapsed != ELAPSED_MAX) begin
            nxt.elapsed = nxt.elapsed + 1'b1;
         end
         if (len != 3'd0) begin
            dur = step_dur(nxt.pattern, nxt.step);
            if (nxt.elapsed > dur) begin
               step_inc = {1'b0, nxt.step} + 4'd1;
               step_wrap = (step_inc >= {1'b0, len}) ? 3'd0 : step_inc[2:0];
               nxt.step = step_wrap;
               nxt.led = step_lvl(nxt.pattern, step_wrap);
               nxt.elapsed = '0;
               advanced = 1'b1;
            end
         end
      end
   end

endmodule
